[rtl/crfm_pkg.sv]
// shared constants and types for the code-point range font map
`default_nettype none
package crfm_pkg;
    localparam int unsigned TBL_ENTRIES = 64;
    localparam int unsigned ADDR_W      = $clog2(TBL_ENTRIES);
    localparam int unsigned CNT_W       = $clog2(TBL_ENTRIES + 1);
    localparam int unsigned CP_W        = 21;
    localparam int unsigned FONT_W      = 4;

    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_INSERT   = 2'd1,
        OP_COMPRESS = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [CP_W-1:0]   cp_lo;
        logic [CP_W-1:0]   cp_hi;
        logic [FONT_W-1:0] font;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);
endpackage
`default_nettype wire

[rtl/crfm_ram.sv]
// simple dual-port table memory, one write and one registered read port
`default_nettype none
module crfm_ram #(
    parameter int unsigned DW = 8,
    parameter int unsigned AW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/codepoint_range_font_map.sv]
// code-point range font map: sorted range table with lookup, insert, compress, clear
// lookup and insert read and check each entry visited; an insert that adds a range then
// moves each later entry up by a read and a write and places it; compress visits every
// entry; clear goes straight to the result. the next beat is taken in the cycle after the
// result is loaded, once the result register is free; one beat at a time, single read port.
// reset clears the entry count and control; table contents are undefined until written
`default_nettype none
module codepoint_range_font_map (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,  // opcode, code_point, range_end, font_number
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata   // found, font_out, status, entry_count, zero pad
);
    import crfm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_EV    = 7'b0000100,
        S_FIN   = 7'b0001000,
        S_SH_RD = 7'b0010000,
        S_SH_WR = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op;
    logic [CP_W-1:0]   r_cp, r_re;
    logic [FONT_W-1:0] r_fn;
    logic [CNT_W-1:0]  r_used, r_k, r_pos;
    logic              r_hv, r_nv;
    logic [CP_W-1:0]   r_hend, r_nstart;
    logic [FONT_W-1:0] r_hfont;
    t_entry            r_w, r_ins;
    logic [ADDR_W-1:0] r_wi;
    logic              r_found;
    logic [FONT_W-1:0] r_font;
    t_status           r_stat;
    logic              r_mv;
    logic [15:0]       r_md;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    t_entry            wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    crfm_ram #(.DW(ENTRY_W), .AW(ADDR_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );
    assign rdata = t_entry'(rdata_raw);

    // clipped insert bounds
    logic [CP_W:0]   f_adj;
    logic [CP_W-1:0] l_adj;
    t_status         ins_st;
    always_comb begin
        f_adj  = (r_hv && r_cp <= r_hend) ? {1'b0, r_hend} + 1'b1 : {1'b0, r_cp};
        l_adj  = r_re;
        ins_st = ST_DONE;
        if (r_cp > r_re || f_adj > {1'b0, r_re}) begin
            ins_st = ST_EMPTY;
        end else if (r_nv && r_nstart <= r_re) begin
            if ({1'b0, r_nstart} <= f_adj) begin
                ins_st = ST_EMPTY;
            end else begin
                l_adj = r_nstart - 1'b1;
            end
        end
        if (ins_st == ST_DONE && r_used >= CNT_W'(TBL_ENTRIES)) begin
            ins_st = ST_FULL;
        end
    end

    always_comb begin
        n_state = r_state;
        raddr   = r_k[ADDR_W-1:0];
        we      = 1'b0;
        waddr   = r_wi;
        wdata   = r_w;
        unique case (r_state)
            S_IDLE: if (i_s_tvalid) begin
                n_state = (t_op'(i_s_tdata[1:0]) == OP_CLEAR) ? S_DONE : S_RD;
            end
            S_RD: begin
                n_state = (r_k == r_used) ? S_FIN : S_EV;
            end
            S_EV: begin
                n_state = S_RD;
                unique case (r_op)
                    OP_LOOKUP: if (rdata.cp_lo > r_cp) n_state = S_FIN;
                    OP_INSERT: if (rdata.cp_lo >= r_cp) n_state = S_FIN;
                    OP_COMPRESS: if (r_k != '0 && rdata.font != r_w.font) we = 1'b1;
                    default: n_state = S_FIN;
                endcase
            end
            S_FIN: begin
                n_state = S_DONE;
                if (r_op == OP_COMPRESS && r_used != '0) we = 1'b1;
                if (r_op == OP_INSERT && ins_st == ST_DONE) n_state = S_SH_RD;
            end
            S_SH_RD: begin
                raddr = ADDR_W'(r_k - 1'b1);
                if (r_k == r_pos) begin
                    we      = 1'b1;
                    waddr   = r_pos[ADDR_W-1:0];
                    wdata   = r_ins;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                we      = 1'b1;
                waddr   = r_k[ADDR_W-1:0];
                wdata   = rdata;
                n_state = S_SH_RD;
            end
            S_DONE: if (!r_mv || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state != S_DONE && i_m_tready) r_mv <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_s_tvalid) begin
                    r_op    <= t_op'(i_s_tdata[1:0]);
                    r_cp    <= i_s_tdata[22:2];
                    r_re    <= i_s_tdata[43:23];
                    r_fn    <= i_s_tdata[47:44];
                    r_k     <= '0;
                    r_wi    <= '0;
                    r_hv    <= 1'b0;
                    r_nv    <= 1'b0;
                    r_found <= 1'b0;
                    r_font  <= '0;
                    r_stat  <= ST_DONE;
                    if (t_op'(i_s_tdata[1:0]) == OP_CLEAR) r_used <= '0;
                end
                S_EV: begin
                    unique case (r_op)
                        OP_LOOKUP: if (rdata.cp_lo <= r_cp) begin
                            r_hv    <= 1'b1;
                            r_hend  <= rdata.cp_hi;
                            r_hfont <= rdata.font;
                            r_k     <= r_k + 1'b1;
                        end
                        OP_INSERT: if (rdata.cp_lo < r_cp) begin
                            r_hv   <= 1'b1;
                            r_hend <= rdata.cp_hi;
                            r_k    <= r_k + 1'b1;
                        end else begin
                            r_nv     <= 1'b1;
                            r_nstart <= rdata.cp_lo;
                        end
                        OP_COMPRESS: begin
                            r_k <= r_k + 1'b1;
                            if (r_k == '0) begin
                                r_w <= rdata;
                            end else if (rdata.font == r_w.font) begin
                                r_w.cp_hi <= rdata.cp_hi;
                            end else begin
                                r_w  <= rdata;
                                r_wi <= r_wi + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_FIN: begin
                    unique case (r_op)
                        OP_LOOKUP: if (r_hv && r_cp <= r_hend) begin
                            r_found <= 1'b1;
                            r_font  <= r_hfont;
                        end
                        OP_INSERT: begin
                            r_stat <= ins_st;
                            r_pos  <= r_k;
                            r_k    <= r_used;
                            r_ins  <= '{cp_lo: f_adj[CP_W-1:0], cp_hi: l_adj, font: r_fn};
                        end
                        OP_COMPRESS: if (r_used != '0) r_used <= CNT_W'(r_wi) + 1'b1;
                        default: ;
                    endcase
                end
                S_SH_RD: if (r_k == r_pos) r_used <= r_used + 1'b1;
                S_SH_WR: r_k <= r_k - 1'b1;
                S_DONE: if (!r_mv || i_m_tready) begin
                    r_mv <= 1'b1;
                    r_md <= {2'b00, r_used, r_stat, r_font, r_found};
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = r_md;

    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TBL_ENTRIES)) else $error("entry count beyond table size");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state register not one-hot");
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !we) else $error("table write while idle");
    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_RD && r_k == r_pos) |=> r_used == $past(r_used) + 1'b1)
        else $error("insert did not add an entry");
endmodule
`default_nettype wire
